// ===== hw/rtl/audio_codec_frame_info_decode_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the audio codec frame info decode unit
// Expect clk and rst in the scope of use.
// ----------------------------------------------------------------------------
`ifndef AUDIO_CODEC_FRAME_INFO_DECODE_UNIT_ASSERT_SVH
`define AUDIO_CODEC_FRAME_INFO_DECODE_UNIT_ASSERT_SVH

// same-cycle implication
`define ACFD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acfd assertion failed");

// next-cycle implication
`define ACFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acfd assertion failed");

`endif

// ===== hw/rtl/acfd_pkg.sv =====
// ----------------------------------------------------------------------------
// acfd_pkg
// Types, constants and tables of the audio codec frame info decode unit.
// ----------------------------------------------------------------------------
`default_nettype none

package acfd_pkg;

  localparam int NUM_W   = 45;
  localparam int DEN_W   = 19;
  localparam int KB_W    = 9;
  localparam int RATE_W  = 17;
  localparam int SAMP_W  = 13;
  localparam int BYTES_W = 16;
  localparam int KBPS_W  = 12;
  localparam int SECS_W  = 32;
  localparam int K125_W  = 16;

  localparam int DEF_LPCM_FRAME_BYTES         = 64;
  localparam int DEF_ATRAC3_FRAME_SAMPLES     = 1024;
  localparam int DEF_ATRAC3PLUS_FRAME_SAMPLES = 2048;

  localparam logic [2:0] CT_LPCM = 3'd0;
  localparam logic [2:0] CT_AT3  = 3'd1;
  localparam logic [2:0] CT_AT3P = 3'd2;
  localparam logic [2:0] CT_MPEG = 3'd3;

  localparam logic [1:0] VER_RESERVED   = 2'd1;
  localparam logic [1:0] VER_1          = 2'd3;
  localparam logic [1:0] LAYER_RESERVED = 2'd0;
  localparam logic [1:0] LAYER_1        = 2'd3;

  localparam logic [SAMP_W-1:0] MP_L1_SAMPLES  = 13'd384;
  localparam logic [SAMP_W-1:0] MP_L23_SAMPLES = 13'd1152;
  localparam logic [RATE_W-1:0] LPCM_RATE      = 17'd44100;
  localparam logic [KBPS_W-1:0] KBPS_MAX       = 12'd4095;

  localparam logic [RATE_W-1:0] ATRAC_RATE [0:7] = '{
    17'd32000, 17'd44100, 17'd48000, 17'd88200, 17'd96000, 17'd0, 17'd0, 17'd0
  };

  // index {rate index, version}: table rate over (4 - version)
  localparam logic [RATE_W-1:0] MPEG_RATE [0:15] = '{
    17'd11025, 17'd14700, 17'd22050, 17'd44100,
    17'd12000, 17'd16000, 17'd24000, 17'd48000,
    17'd8000,  17'd10666, 17'd16000, 17'd32000,
    17'd0,     17'd0,     17'd0,     17'd0
  };

  // index {row, bitrate index}
  localparam logic [KB_W-1:0] KB_TAB [0:79] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0,
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0,
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0,
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0,
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
  };

  typedef struct packed {
    logic [2:0]  codec_type;
    logic [7:0]  info_byte1;
    logic [7:0]  info_byte2;
    logic [7:0]  info_byte3;
    logic [7:0]  info_byte4;
    logic [31:0] frame_count;
  } req_t;

  typedef struct packed {
    logic [BYTES_W-1:0] frame_bytes;
    logic [SAMP_W-1:0]  frame_samples;
    logic [RATE_W-1:0]  rate_hz;
    logic [KBPS_W-1:0]  bitrate_kbps;
    logic [SECS_W-1:0]  duration_seconds;
    logic               divide_error;
  } rsp_t;

  typedef struct packed {
    logic [2:0]         codec_type;
    logic [BYTES_W-1:0] bytes;
    logic [SAMP_W-1:0]  samples;
    logic [RATE_W-1:0]  rate;
    logic [KB_W-1:0]    kbps;
    logic [K125_W-1:0]  kbps125;
    logic [DEN_W-1:0]   samp125;
    logic               layer1;
    logic [31:0]        frames;
  } dec_t;

  typedef struct packed {
    logic [2:0]         codec_type;
    logic [BYTES_W-1:0] bytes;
    logic [SAMP_W-1:0]  samples;
    logic [RATE_W-1:0]  rate;
    logic [KB_W-1:0]    kbps;
    logic               layer1;
    logic               d1_zero;
    logic               rate_zero;
  } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/audio_codec_frame_info_decode_unit.sv =====
// ----------------------------------------------------------------------------
// audio_codec_frame_info_decode_unit
// Decodes codec type and info bytes into frame size, samples, sample rate,
// bitrate and track length in seconds.
//
// Usage:
//   The req channel takes one header (codec type, four info bytes, frame
//   count) per transfer; the rsp channel returns one result per header, in
//   order. Both channels use valid/ready.
//   From req transfer to rsp valid a header passes one decode stage, one
//   multiply stage, 45 divider stages (one quotient bit each, both
//   divisions side by side) and the output register. Throughput is one
//   header per cycle unless the receiver stalls; the dividers set the depth.
//   Reset clears all valid bits; no result is pending afterwards.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and req_ready drops until the result transfers; nothing is lost.
//   A zero divisor yields a zero quotient and sets divide_error.
// ----------------------------------------------------------------------------
`default_nettype none
`include "audio_codec_frame_info_decode_unit_assert.svh"

module audio_codec_frame_info_decode_unit #(
  parameter int LPCM_FRAME_BYTES         = acfd_pkg::DEF_LPCM_FRAME_BYTES,
  parameter int ATRAC3_FRAME_SAMPLES     = acfd_pkg::DEF_ATRAC3_FRAME_SAMPLES,
  parameter int ATRAC3PLUS_FRAME_SAMPLES = acfd_pkg::DEF_ATRAC3PLUS_FRAME_SAMPLES
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire acfd_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output acfd_pkg::rsp_t      rsp
);
  import acfd_pkg::*;

  logic             en;
  dec_t             dec;
  logic [NUM_W-1:0] n1;
  logic [DEN_W-1:0] d1;
  logic [NUM_W-1:0] n2;
  logic [DEN_W-1:0] d2;
  side_t            side;
  logic [NUM_W-1:0] q1;
  logic [NUM_W-1:0] q2;
  logic [NUM_W+1:0] vld;
  side_t            sd [0:NUM_W-1];
  side_t            s;
  rsp_t             rsp_next;

  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en;

  acfd_decode #(
    .LPCM_FRAME_BYTES        (LPCM_FRAME_BYTES),
    .ATRAC3_FRAME_SAMPLES    (ATRAC3_FRAME_SAMPLES),
    .ATRAC3PLUS_FRAME_SAMPLES(ATRAC3PLUS_FRAME_SAMPLES)
  ) u_decode (
    .clk(clk),
    .en (en),
    .req(req),
    .dec(dec)
  );

  acfd_mult u_mult (
    .clk (clk),
    .en  (en),
    .dec (dec),
    .n1  (n1),
    .d1  (d1),
    .n2  (n2),
    .d2  (d2),
    .side(side)
  );

  acfd_div #(.NW(NUM_W), .DW(DEN_W)) u_div_frame (
    .clk(clk),
    .en (en),
    .num(n1),
    .den(d1),
    .quo(q1)
  );

  acfd_div #(.NW(NUM_W), .DW(DEN_W)) u_div_secs (
    .clk(clk),
    .en (en),
    .num(n2),
    .den(d2),
    .quo(q2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side;
      for (int k = 1; k < NUM_W; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  assign s = sd[NUM_W-1];

  always_comb begin
    rsp_next.frame_samples = s.samples;
    rsp_next.rate_hz       = s.rate;
    rsp_next.divide_error  = s.d1_zero || s.rate_zero;
    rsp_next.duration_seconds = s.rate_zero ? '0 : q2[SECS_W-1:0];
    if (s.codec_type == CT_MPEG) begin
      rsp_next.frame_bytes  = s.d1_zero ? '0 :
                              (q1[BYTES_W-1:0] & (s.layer1 ? ~BYTES_W'(3) : '1));
      rsp_next.bitrate_kbps = KBPS_W'(s.kbps);
    end else if (s.codec_type <= CT_AT3P) begin
      rsp_next.frame_bytes  = s.bytes;
      if (s.d1_zero) begin
        rsp_next.bitrate_kbps = '0;
      end else if (q1 > NUM_W'(KBPS_MAX)) begin
        rsp_next.bitrate_kbps = KBPS_MAX;
      end else begin
        rsp_next.bitrate_kbps = q1[KBPS_W-1:0];
      end
    end else begin
      rsp_next.frame_bytes  = '0;
      rsp_next.bitrate_kbps = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NUM_W:0], req_valid};
      rsp_valid <= vld[NUM_W+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

  `ACFD_ASSERT(a_rate_zero, rsp_valid && rsp.rate_hz == '0, rsp.divide_error && rsp.duration_seconds == '0)
  `ACFD_ASSERT(a_unknown, rsp_valid && rsp.frame_samples == '0, rsp.divide_error && rsp.frame_bytes == '0 && rsp.rate_hz == '0)
  `ACFD_ASSERT_NEXT(a_enter, req_valid && req_ready, vld[0])
  `ACFD_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, $stable(vld))

endmodule

`default_nettype wire

// ===== hw/rtl/acfd_decode.sv =====
// ----------------------------------------------------------------------------
// acfd_decode
// First stage: table lookups and field decode per codec type.
// ----------------------------------------------------------------------------
`default_nettype none

module acfd_decode #(
  parameter int LPCM_FRAME_BYTES         = acfd_pkg::DEF_LPCM_FRAME_BYTES,
  parameter int ATRAC3_FRAME_SAMPLES     = acfd_pkg::DEF_ATRAC3_FRAME_SAMPLES,
  parameter int ATRAC3PLUS_FRAME_SAMPLES = acfd_pkg::DEF_ATRAC3PLUS_FRAME_SAMPLES
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire acfd_pkg::req_t req,
  output acfd_pkg::dec_t     dec
);
  import acfd_pkg::*;

  dec_t       dec_next;
  logic [1:0] ver;
  logic [1:0] layer;
  logic       is_l1;
  logic [2:0] row;
  logic [10:0] at3p_units;

  assign ver        = req.info_byte3[7:6];
  assign layer      = req.info_byte3[5:4];
  assign is_l1      = (layer == LAYER_1);
  assign at3p_units = {1'b0, req.info_byte1[1:0], req.info_byte2} + 11'd1;

  always_comb begin
    dec_next            = '0;
    row                 = 3'd0;
    dec_next.codec_type = req.codec_type;
    dec_next.frames     = req.frame_count;
    unique case (req.codec_type)
      CT_MPEG: begin
        dec_next.samples = is_l1 ? MP_L1_SAMPLES : MP_L23_SAMPLES;
        dec_next.rate    = MPEG_RATE[{req.info_byte4[7:6], ver}];
        dec_next.layer1  = is_l1;
        if (ver != VER_RESERVED && layer != LAYER_RESERVED) begin
          row           = (ver == VER_1) ? (3'd3 - {1'b0, layer}) : (is_l1 ? 3'd3 : 3'd4);
          dec_next.kbps = KB_TAB[{row, req.info_byte3[3:0]}];
        end
      end
      CT_LPCM: begin
        dec_next.bytes   = BYTES_W'(LPCM_FRAME_BYTES);
        dec_next.samples = SAMP_W'(LPCM_FRAME_BYTES / 4);
        dec_next.rate    = LPCM_RATE;
      end
      CT_AT3: begin
        dec_next.bytes   = {5'b0, req.info_byte2, 3'b0};
        dec_next.samples = SAMP_W'(ATRAC3_FRAME_SAMPLES);
        dec_next.rate    = ATRAC_RATE[req.info_byte1[7:5]];
      end
      CT_AT3P: begin
        dec_next.bytes   = {2'b0, at3p_units, 3'b0};
        dec_next.samples = SAMP_W'(ATRAC3PLUS_FRAME_SAMPLES);
        dec_next.rate    = ATRAC_RATE[req.info_byte1[7:5]];
      end
      default: begin
        dec_next.samples = '0;
      end
    endcase
    dec_next.kbps125 = K125_W'(dec_next.kbps) * K125_W'(125);
    dec_next.samp125 = DEN_W'(dec_next.samples) * DEN_W'(125);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec <= dec_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/acfd_mult.sv =====
// ----------------------------------------------------------------------------
// acfd_mult
// Second stage: numerator products and divisor select for both dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module acfd_mult (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire acfd_pkg::dec_t            dec,
  output logic [acfd_pkg::NUM_W-1:0]     n1,
  output logic [acfd_pkg::DEN_W-1:0]     d1,
  output logic [acfd_pkg::NUM_W-1:0]     n2,
  output logic [acfd_pkg::DEN_W-1:0]     d2,
  output acfd_pkg::side_t                side
);
  import acfd_pkg::*;

  logic [28:0]      p_mpeg;
  logic [32:0]      p_atrac;
  logic [NUM_W-1:0] p_secs;
  logic             is_mpeg;
  logic             is_known;
  logic [NUM_W-1:0] n1_next;
  logic [DEN_W-1:0] d1_next;
  side_t            side_next;

  assign is_mpeg  = (dec.codec_type == CT_MPEG);
  assign is_known = (dec.codec_type <= CT_AT3P);
  assign p_mpeg   = dec.samples * dec.kbps125;
  assign p_atrac  = dec.bytes * dec.rate;
  assign p_secs   = dec.frames * dec.samples;

  always_comb begin
    if (is_mpeg) begin
      n1_next = NUM_W'(p_mpeg);
      d1_next = DEN_W'(dec.rate);
    end else if (is_known) begin
      n1_next = NUM_W'(p_atrac);
      d1_next = dec.samp125;
    end else begin
      n1_next = '0;
      d1_next = '0;
    end
    side_next.codec_type = dec.codec_type;
    side_next.bytes      = dec.bytes;
    side_next.samples    = dec.samples;
    side_next.rate       = dec.rate;
    side_next.kbps       = dec.kbps;
    side_next.layer1     = dec.layer1;
    side_next.d1_zero    = (d1_next == '0);
    side_next.rate_zero  = (dec.rate == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1   <= n1_next;
      d1   <= d1_next;
      n2   <= p_secs;
      d2   <= DEN_W'(dec.rate);
      side <= side_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/acfd_div.sv =====
// ----------------------------------------------------------------------------
// acfd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module acfd_div #(
  parameter int NW = 45,
  parameter int DW = 19
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic [NW-1:0]      quo
);

  logic [DW-1:0] rem_q [1:NW];
  logic [NW-1:0] num_q [1:NW];
  logic [NW-1:0] quo_q [1:NW];
  logic [DW-1:0] den_q [1:NW];

  logic [DW-1:0] rem_i [0:NW-1];
  logic [NW-1:0] num_i [0:NW-1];
  logic [NW-1:0] quo_i [0:NW-1];
  logic [DW-1:0] den_i [0:NW-1];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_i[k] = '0;
      assign num_i[k] = num;
      assign quo_i[k] = '0;
      assign den_i[k] = den;
    end else begin : g_rest
      assign rem_i[k] = rem_q[k];
      assign num_i[k] = num_q[k];
      assign quo_i[k] = quo_q[k];
      assign den_i[k] = den_q[k];
    end

    assign trial = {rem_i[k], num_i[k][NW-1]};
    assign diff  = trial - {1'b0, den_i[k]};
    assign ge    = (trial >= {1'b0, den_i[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        num_q[k+1] <= num_i[k] << 1;
        quo_q[k+1] <= {quo_i[k][NW-2:0], ge};
        den_q[k+1] <= den_i[k];
      end
    end
  end

  assign quo = quo_q[NW];

endmodule

`default_nettype wire

// ===== tb/acfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acfd_checker
// Watches the req and rsp channels of the frame info decode unit, computes
// the expected frame size, samples, rate, bitrate and duration of every
// accepted header and compares each result with the oldest expectation.
// ----------------------------------------------------------------------------
module acfd_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  acfd_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  acfd_pkg::rsp_t rsp,
  output int             errors,
  output int             pending
);
  import acfd_pkg::*;

  rsp_t want_q[$];

  function automatic logic [63:0] div_or_flag(input logic [63:0] n, input logic [63:0] d,
                                              inout logic err);
    if (d == '0) begin
      err = 1'b1;
      return 64'd0;
    end
    return n / d;
  endfunction

  function automatic logic [16:0] atrac_rate(input logic [2:0] idx);
    case (idx)
      3'd0: return 17'd32000;
      3'd1: return 17'd44100;
      3'd2: return 17'd48000;
      3'd3: return 17'd88200;
      3'd4: return 17'd96000;
      default: return 17'd0;
    endcase
  endfunction

  function automatic logic [63:0] mpeg_kbps(input logic [2:0] row, input logic [3:0] idx);
    int t1 [16] = '{0,32,64,96,128,160,192,224,256,288,320,352,384,416,448,0};
    int t2 [16] = '{0,32,48,56,64,80,96,112,128,160,192,224,256,320,384,0};
    int t3 [16] = '{0,32,40,48,56,64,80,96,112,128,160,192,224,256,320,0};
    int t4 [16] = '{0,32,48,56,64,80,96,112,128,144,160,176,192,224,256,0};
    int t5 [16] = '{0,8,16,24,32,40,48,56,64,80,96,112,128,144,160,0};
    case (row)
      3'd0: return 64'(t1[idx]);
      3'd1: return 64'(t2[idx]);
      3'd2: return 64'(t3[idx]);
      3'd3: return 64'(t4[idx]);
      default: return 64'(t5[idx]);
    endcase
  endfunction

  function automatic rsp_t decode_header(input req_t h);
    rsp_t r;
    logic err;
    logic [63:0] bytes, samples, rate, kbps, secs, base;
    logic [1:0] ver, layer;
    logic [2:0] row;
    err = 1'b0;
    bytes = '0;
    samples = '0;
    rate = '0;
    kbps = '0;
    ver = h.info_byte3[7:6];
    layer = h.info_byte3[5:4];
    if (h.codec_type == CT_MPEG) begin
      samples = (layer == LAYER_1) ? 64'd384 : 64'd1152;
      case (h.info_byte4[7:6])
        2'd0: base = 64'd44100;
        2'd1: base = 64'd48000;
        2'd2: base = 64'd32000;
        default: base = '0;
      endcase
      rate = base / (64'd4 - 64'(ver));
      if (ver != VER_RESERVED && layer != LAYER_RESERVED) begin
        if (ver == VER_1) row = 3'd3 - {1'b0, layer};
        else row = (layer == LAYER_1) ? 3'd3 : 3'd4;
        kbps = mpeg_kbps(row, h.info_byte3[3:0]);
      end
      bytes = div_or_flag(samples * (kbps * 64'd125), rate, err);
      if (layer == LAYER_1) bytes = bytes & ~64'd3;
    end else if (h.codec_type <= CT_AT3P) begin
      if (h.codec_type == CT_LPCM) begin
        bytes = 64'(DEF_LPCM_FRAME_BYTES);
        samples = 64'(DEF_LPCM_FRAME_BYTES / 4);
        rate = 64'd44100;
      end else if (h.codec_type == CT_AT3) begin
        bytes = 64'(h.info_byte2) * 64'd8;
        samples = 64'(DEF_ATRAC3_FRAME_SAMPLES);
        rate = 64'(atrac_rate(h.info_byte1[7:5]));
      end else begin
        bytes = (64'({h.info_byte1[1:0], h.info_byte2}) + 64'd1) * 64'd8;
        samples = 64'(DEF_ATRAC3PLUS_FRAME_SAMPLES);
        rate = 64'(atrac_rate(h.info_byte1[7:5]));
      end
      kbps = div_or_flag(bytes * rate, 64'd125 * samples, err);
      if (kbps > 64'd4095) kbps = 64'd4095;
    end else begin
      kbps = div_or_flag(64'd0, 64'd0, err);
    end
    secs = div_or_flag(64'(h.frame_count) * samples, rate, err);
    r.frame_bytes = bytes[15:0];
    r.frame_samples = samples[12:0];
    r.rate_hz = rate[16:0];
    r.bitrate_kbps = kbps[11:0];
    r.duration_seconds = secs[31:0];
    r.divide_error = err;
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t w;
    if (rst) begin
      errors <= 0;
    end else begin
      if (req_valid && req_ready) want_q.push_back(decode_header(req));
      if (rsp_valid && rsp_ready) begin
        if (want_q.size() == 0) begin
          $error("unexpected result transfer");
          errors <= errors + 1;
        end else begin
          w = want_q.pop_front();
          if (rsp !== w) begin
            if (rsp.frame_bytes !== w.frame_bytes)
              $error("frame_bytes exp %0d got %0d", w.frame_bytes, rsp.frame_bytes);
            if (rsp.frame_samples !== w.frame_samples)
              $error("frame_samples exp %0d got %0d", w.frame_samples, rsp.frame_samples);
            if (rsp.rate_hz !== w.rate_hz)
              $error("rate_hz exp %0d got %0d", w.rate_hz, rsp.rate_hz);
            if (rsp.bitrate_kbps !== w.bitrate_kbps)
              $error("bitrate_kbps exp %0d got %0d", w.bitrate_kbps, rsp.bitrate_kbps);
            if (rsp.duration_seconds !== w.duration_seconds)
              $error("duration_seconds exp %0d got %0d", w.duration_seconds,
                     rsp.duration_seconds);
            if (rsp.divide_error !== w.divide_error)
              $error("divide_error exp %0d got %0d", w.divide_error, rsp.divide_error);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= want_q.size();
  end
endmodule

// ===== tb/tb_audio_codec_frame_info_decode_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_codec_frame_info_decode_unit
// Drives directed and random codec headers into the decode unit with random
// idle cycles on both channels; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_audio_codec_frame_info_decode_unit;
  import acfd_pkg::*;

  logic clk, rst;
  logic req_valid, req_ready, rsp_valid, rsp_ready;
  req_t req;
  rsp_t rsp;
  int errors, pending;
  int send_idle_pct, recv_idle_pct;
  int stuck_cycles;

  audio_codec_frame_info_decode_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  acfd_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  always @(posedge clk) begin
    if (stuck_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_header(input req_t h);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= h;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic req_t random_header();
    req_t h;
    h = 67'({$urandom, $urandom, $urandom});
    case ($urandom_range(9))
      0, 1: h.codec_type = CT_LPCM;
      2, 3: h.codec_type = CT_AT3;
      4, 5: h.codec_type = CT_AT3P;
      6, 7, 8: h.codec_type = CT_MPEG;
      default: h.codec_type = 3'(4 + $urandom_range(3));
    endcase
    case ($urandom_range(3))
      0: h.frame_count = $urandom_range(1000);
      1: h.frame_count = 32'hFFFF_FFFF - $urandom_range(3);
      default: h.frame_count = $urandom;
    endcase
    return h;
  endfunction

  initial begin
    req_t h;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < 24; i++) begin
      h = '0;
      h.codec_type = 3'(i % 8);
      h.info_byte1 = (i & 1) ? 8'hFF : {i[2:0], 5'd0};
      h.info_byte2 = (i & 2) ? 8'hFF : 8'h00;
      h.info_byte3 = {i[1:0], i[3:2], i[3:0] ^ 4'hF};
      h.info_byte4 = {i[4:3], 6'h3F};
      h.frame_count = (i & 4) ? 32'hFFFF_FFFF : i;
      if (i >= 16) begin
        h.codec_type = CT_MPEG;
        h.info_byte3 = {2'd3, i[1:0], 4'd14};
        h.info_byte4 = {i[3:2], 6'd0};
      end
      send_header(h);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 59 : 0;
      recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 25 : 0;
      for (int i = 0; i < 550; i++) send_header(random_header());
    end
    req_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/acfd_pkg.sv
hw/rtl/acfd_decode.sv
hw/rtl/acfd_mult.sv
hw/rtl/acfd_div.sv
hw/rtl/audio_codec_frame_info_decode_unit.sv
tb/acfd_checker.sv
tb/tb_audio_codec_frame_info_decode_unit.sv
